// ----- design/dmt_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmt_pkg
// Shared types and constants for the truncated double multiplier.
// ---------------------------------------------------------------------------
package dmt_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned ExpW   = 11;
  localparam int unsigned FracW  = 52;
  localparam int unsigned HiW    = 32;  // upper mantissa part, bits 52..21
  localparam int unsigned LoW    = 21;  // lower mantissa part, bits 20..0
  localparam int unsigned ESumW  = ExpW + 1;
  localparam int unsigned EResW  = ESumW + 1;

  localparam logic [WordW-1:0] RoundBig   = 64'h0000_0000_0000_0400;
  localparam logic [WordW-1:0] RoundSmall = 64'h0000_0000_0000_0200;
  localparam logic [EResW-1:0] BiasBig    = 13'd1022;
  localparam logic [EResW-1:0] BiasSmall  = 13'd1023;
  localparam logic [EResW-1:0] ExpLimit   = 13'd2047;
  localparam logic [HiW-1:0]   ClearHid   = 32'hFFEF_FFFF;
  localparam logic [HiW-1:0]   PosInfHi   = 32'h7FF0_0000;
  localparam logic [HiW-1:0]   NegInfHi   = 32'hFFF0_0000;

  // side info that travels beside the mantissa data
  typedef struct packed {
    logic             sign;
    logic             zero;
    logic [ESumW-1:0] esum;
  } dmt_meta_t;

  typedef struct packed {
    logic [WordW-1:0] product;
    logic             overflow;
  } dmt_res_t;

endpackage

// ----- design/dmt_pack.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmt_pack
// Rounding, normalization and packing of the 64-bit mantissa sum.
// ---------------------------------------------------------------------------
module dmt_pack (
  input  logic [63:0]        acc_i,
  input  dmt_pkg::dmt_meta_t meta_i,
  output dmt_pkg::dmt_res_t  res_o
);
  import dmt_pkg::*;

  logic [WordW-1:0] sum_big, sum_small, shifted;
  logic [EResW-1:0] ex;
  logic [HiW-1:0]   hi_word;
  logic             ovf;

  always_comb begin
    sum_big   = acc_i + RoundBig;
    sum_small = acc_i + RoundSmall;
    priority if (acc_i[WordW-1]) begin
      shifted = sum_big >> 11;
      ex      = {1'b0, meta_i.esum} - BiasBig;
    end else if (sum_small[WordW-1]) begin
      shifted = sum_small >> 11;
      ex      = {1'b0, meta_i.esum} - BiasBig;
    end else begin
      shifted = sum_small >> 10;
      ex      = {1'b0, meta_i.esum} - BiasSmall;
    end
    ovf     = $signed(ex) >= $signed(ExpLimit);
    // exponent ORed in unmasked, two's complement truncated to 12 bits
    hi_word = {meta_i.sign, 31'b0} | {ex[ESumW-1:0], 20'b0}
            | (shifted[WordW-1:HiW] & ClearHid);

    priority if (meta_i.zero) begin
      res_o.product  = {meta_i.sign, 63'b0};
      res_o.overflow = 1'b0;
    end else if (ovf) begin
      res_o.product  = {(meta_i.sign ? NegInfHi : PosInfHi), 32'b0};
      res_o.overflow = 1'b1;
    end else begin
      res_o.product  = {hi_word, shifted[HiW-1:0]};
      res_o.overflow = 1'b0;
    end
  end

endmodule

// ----- design/double_multiply_truncated.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_multiply_truncated
// Four-stage pipelined multiplier for double bit patterns with a truncated
// mantissa product (low-by-low term dropped) and an overflow flag.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------
//  in       | in        | in_valid_i/in_stall_o | operand_a_i, operand_b_i
//  out      | out       | out_valid_o/out_stall_i | product_o, overflow_o
//
//  One transfer per cycle sustained while out_stall_i is low. Stages, in
//  order from input to result valid: decode, multiply (three 32-bit-class
//  products in parallel), accumulate, round/pack into the output register.
//  Each stage holds its own valid bit and moves when the next one is empty
//  or moving, so bubbles are squeezed out under a downstream stall.
//  Reset clears the valid bits only; datapath registers are not reset.
// ---------------------------------------------------------------------------
module double_multiply_truncated (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] product_o,
  output logic        overflow_o
);
  import dmt_pkg::*;

  // stage valids and move enables
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic en1, en2, en3, en_out;

  // stage 1: split mantissas, sum exponents
  logic [HiW-1:0]   s1_ah_q, s1_bh_q;
  logic [LoW-1:0]   s1_al_q, s1_bl_q;
  dmt_meta_t        s1_meta_q;
  // stage 2: partial products
  logic [WordW-1:0]     s2_hh_q;
  logic [HiW+LoW-1:0]   s2_ab_q, s2_ba_q;
  dmt_meta_t            s2_meta_q;
  // stage 3: truncated sum
  logic [WordW-1:0] s3_acc_q;
  dmt_meta_t        s3_meta_q;
  // output register
  dmt_res_t         out_q;

  logic [FracW:0]   man_a, man_b;
  dmt_meta_t        s1_meta_d;
  logic [WordW-1:0] acc_d;
  dmt_res_t         res_d;

  // backward enable chain: a stage moves when empty or its successor moves
  assign en_out     = !out_valid_q || !out_stall_i;
  assign en3        = !s3_valid_q || en_out;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign in_stall_o = !en1;

  always_comb begin
    // hidden one always forced on
    man_a          = {1'b1, operand_a_i[FracW-1:0]};
    man_b          = {1'b1, operand_b_i[FracW-1:0]};
    s1_meta_d.sign = operand_a_i[WordW-1] ^ operand_b_i[WordW-1];
    s1_meta_d.zero = (operand_a_i[WordW-2:0] == '0) || (operand_b_i[WordW-2:0] == '0);
    s1_meta_d.esum = {1'b0, operand_a_i[WordW-2:FracW]}
                   + {1'b0, operand_b_i[WordW-2:FracW]};
  end

  // cross products enter shifted right by the low-part width; wraps mod 2^64
  assign acc_d = s2_hh_q + WordW'(s2_ab_q >> LoW) + WordW'(s2_ba_q >> LoW);

  dmt_pack u_pack (
    .acc_i  (s3_acc_q),
    .meta_i (s3_meta_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    s1_valid_q  <= in_valid_i;
      if (en2)    s2_valid_q  <= s1_valid_q;
      if (en3)    s3_valid_q  <= s2_valid_q;
      if (en_out) out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_ah_q   <= man_a[FracW:LoW];
      s1_bh_q   <= man_b[FracW:LoW];
      s1_al_q   <= man_a[LoW-1:0];
      s1_bl_q   <= man_b[LoW-1:0];
      s1_meta_q <= s1_meta_d;
    end
    if (en2) begin
      s2_hh_q   <= WordW'(s1_ah_q) * WordW'(s1_bh_q);
      s2_ab_q   <= (HiW+LoW)'(s1_al_q) * (HiW+LoW)'(s1_bh_q);
      s2_ba_q   <= (HiW+LoW)'(s1_bl_q) * (HiW+LoW)'(s1_ah_q);
      s2_meta_q <= s1_meta_q;
    end
    if (en3) begin
      s3_acc_q  <= acc_d;
      s3_meta_q <= s2_meta_q;
    end
    if (en_out) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign product_o   = out_q.product;
  assign overflow_o  = out_q.overflow;

endmodule

// ----- design/dmt_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmt_checker
// Port-level checks for the truncated double multiplier, bound to the top.
// ---------------------------------------------------------------------------
module dmt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] product_o,
  input logic        overflow_o
);

  // a stalled result stays valid
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result holds its payload
  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(product_o) && $stable(overflow_o))
    else $error("result changed while stalled");

  // overflow always returns a signed infinity
  a_ovf_inf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> product_o[62:0] == 63'h7FF0_0000_0000_0000)
    else $error("overflow without infinity pattern");

  // with out_stall_i low while it passes the stages, an accepted item shows up as a valid result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o)
    else $error("result missing after pipeline latency");

endmodule

bind double_multiply_truncated dmt_checker u_dmt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .product_o   (product_o),
  .overflow_o  (overflow_o)
);
